>>> rtl/core/lbp_3x3_operator_assert.svh
// Assertion macros shared by the LBP operator RTL
`ifndef LBP_3X3_OPERATOR_ASSERT_SVH
`define LBP_3X3_OPERATOR_ASSERT_SVH

// condition never holds outside reset
`define LBP_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lbp assertion failed");

// antecedent implies consequent in the same cycle
`define LBP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbp assertion failed");

// antecedent implies consequent in the next cycle
`define LBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbp assertion failed");

`endif

>>> rtl/core/lbp_pkg.sv
// Shared types and constants of the LBP operator
package lbp_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int MAX_HEIGHT        = 4096;
  localparam int MIN_SIZE          = 3;
  localparam int PIXEL_W           = 8;
  localparam int ROW_W             = 12;
  localparam int SIZE_W            = 13;
  localparam int CFG_INDEX_W       = 1;
  localparam int CFG_DATA_W        = 13;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  localparam int BIT_TOP_LEFT     = 0;
  localparam int BIT_TOP          = 1;
  localparam int BIT_TOP_RIGHT    = 2;
  localparam int BIT_RIGHT        = 3;
  localparam int BIT_BOTTOM_RIGHT = 4;
  localparam int BIT_BOTTOM       = 5;
  localparam int BIT_BOTTOM_LEFT  = 6;
  localparam int BIT_LEFT         = 7;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [PIXEL_W-1:0] upper;
    logic [PIXEL_W-1:0] middle;
    logic               emit;
    logic               last;
  } lbp_word_t;

  typedef struct packed {
    logic      valid;
    lbp_word_t word;
  } lbp_push_t;

  typedef struct packed {
    logic      valid;
    lbp_word_t word;
  } lbp_head_t;

endpackage

>>> rtl/core/lbp_front.sv
// Front end: raster position, line stores and classification of each pixel
`include "lbp_3x3_operator_assert.svh"

module lbp_front #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [lbp_pkg::SIZE_W-1:0]            image_width,
  input  logic [lbp_pkg::SIZE_W-1:0]            image_height,
  input  logic [lbp_pkg::PIXEL_W-1:0]           gray_pixel,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lbp_pkg::QUEUE_COUNT_W-1:0]     queue_count,
  output lbp_pkg::lbp_push_t                    push
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int QC_W  = lbp_pkg::QUEUE_COUNT_W;

  logic [COL_W-1:0]                col, col_next;
  logic [lbp_pkg::ROW_W-1:0]       row, row_next;
  logic [WW-1:0]                   w_eff, col_inc;
  logic [lbp_pkg::SIZE_W-1:0]      h_eff, row_inc;
  logic                            col_end, row_end, accept;

  logic                            f1_valid;
  logic [COL_W-1:0]                f1_addr;
  logic [lbp_pkg::PIXEL_W-1:0]     f1_pixel;
  logic                            f1_emit, f1_last;
  logic [lbp_pkg::PIXEL_W-1:0]     upper_rd, middle_rd;

  logic [lbp_pkg::PIXEL_W-1:0]     upper_mem  [MAX_WIDTH];
  logic [lbp_pkg::PIXEL_W-1:0]     middle_mem [MAX_WIDTH];

  always_comb begin
    if (image_width < lbp_pkg::SIZE_W'(lbp_pkg::MIN_SIZE)) begin
      w_eff = WW'(lbp_pkg::MIN_SIZE);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < lbp_pkg::SIZE_W'(lbp_pkg::MIN_SIZE)) begin
      h_eff = lbp_pkg::SIZE_W'(lbp_pkg::MIN_SIZE);
    end else if (32'(image_height) > 32'(lbp_pkg::MAX_HEIGHT)) begin
      h_eff = lbp_pkg::SIZE_W'(lbp_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign col_inc = WW'(col) + WW'(1);
  assign row_inc = lbp_pkg::SIZE_W'(row) + lbp_pkg::SIZE_W'(1);
  assign col_end = (col_inc >= w_eff);
  assign row_end = (row_inc >= h_eff);

  assign in_stall = (({1'b0, queue_count} + (QC_W + 1)'(f1_valid))
                     >= (QC_W + 1)'(lbp_pkg::QUEUE_DEPTH));
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    col_next = col;
    row_next = row;
    if (accept) begin
      if (col_end) begin
        col_next = '0;
        row_next = row_end ? '0 : row_inc[lbp_pkg::ROW_W-1:0];
      end else begin
        col_next = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      f1_valid <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_addr  <= col;
      f1_pixel <= gray_pixel;
      f1_emit  <= (row >= lbp_pkg::ROW_W'(2)) && (col >= COL_W'(2));
      f1_last  <= row_end && col_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upper_rd  <= upper_mem[col];
      middle_rd <= middle_mem[col];
    end
    if (f1_valid) begin
      upper_mem[f1_addr]  <= middle_rd;
      middle_mem[f1_addr] <= f1_pixel;
    end
  end

  always_comb begin
    push.valid       = f1_valid;
    push.word.pixel  = f1_pixel;
    push.word.upper  = upper_rd;
    push.word.middle = middle_rd;
    push.word.emit   = f1_emit;
    push.word.last   = f1_last;
  end

  `LBP_ASSERT_NEVER(a_no_rw_clash, clk, rst, accept && f1_valid && (col == f1_addr))
  `LBP_ASSERT_IMPLIES(a_room_for_word, clk, rst, f1_valid,
                      queue_count < QC_W'(lbp_pkg::QUEUE_DEPTH))
  `LBP_ASSERT_NEXT(a_accept_pushes, clk, rst, accept, f1_valid)

endmodule

>>> rtl/core/lbp_queue.sv
// Short word queue between front end and back end
`include "lbp_3x3_operator_assert.svh"

module lbp_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  lbp_pkg::lbp_push_t                push,
  input  logic                              pop,
  output lbp_pkg::lbp_head_t                head,
  output logic [lbp_pkg::QUEUE_COUNT_W-1:0] count
);

  localparam int PW = lbp_pkg::QUEUE_PTR_W;
  localparam int CW = lbp_pkg::QUEUE_COUNT_W;

  lbp_pkg::lbp_word_t  entries [lbp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr, rd_ptr;
  logic                do_pop;

  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.valid) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.word;
    end
  end

  assign head.valid = (count != '0);
  assign head.word  = entries[rd_ptr];

  `LBP_ASSERT_NEVER(a_no_overflow, clk, rst,
                    push.valid && !do_pop && (count == CW'(lbp_pkg::QUEUE_DEPTH)))
  `LBP_ASSERT_NEVER(a_no_underflow, clk, rst, pop && (count == '0))
  `LBP_ASSERT_IMPLIES(a_ptr_track, clk, rst, count == '0, wr_ptr == rd_ptr)

endmodule

>>> rtl/core/lbp_back.sv
// Back end: 3x3 window, centre comparisons and output register
module lbp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  lbp_pkg::lbp_head_t          head,
  output logic                        pop,
  output logic [lbp_pkg::PIXEL_W-1:0] lbp_code,
  output logic                        last_code,
  output logic                        out_valid,
  input  logic                        out_stall
);

  logic [lbp_pkg::PIXEL_W-1:0] win [6];
  logic [lbp_pkg::PIXEL_W-1:0] ctr;
  logic [lbp_pkg::PIXEL_W-1:0] code;

  assign pop = head.valid && (!out_valid || !out_stall);
  assign ctr = win[4];

  always_comb begin
    code = '0;
    code[lbp_pkg::BIT_TOP_LEFT]     = (ctr >= win[0]);
    code[lbp_pkg::BIT_TOP]          = (ctr >= win[3]);
    code[lbp_pkg::BIT_TOP_RIGHT]    = (ctr >= head.word.upper);
    code[lbp_pkg::BIT_RIGHT]        = (ctr >= head.word.middle);
    code[lbp_pkg::BIT_BOTTOM_RIGHT] = (ctr >= head.word.pixel);
    code[lbp_pkg::BIT_BOTTOM]       = (ctr >= win[5]);
    code[lbp_pkg::BIT_BOTTOM_LEFT]  = (ctr >= win[2]);
    code[lbp_pkg::BIT_LEFT]         = (ctr >= win[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        win[0]    <= win[3];
        win[1]    <= win[4];
        win[2]    <= win[5];
        win[3]    <= head.word.upper;
        win[4]    <= head.word.middle;
        win[5]    <= head.word.pixel;
        out_valid <= head.word.emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lbp_code  <= code;
      last_code <= head.word.last;
    end
  end

endmodule

>>> rtl/core/lbp_3x3_operator.sv
// Top level of the 3x3 local binary pattern operator
// Takes one grayscale pixel per clock in raster order and gives one 8-bit code per
// interior pixel, with last_code on the final code of the frame; border pixels give
// no word. An accepted pixel passes the front-end register, the queue and the output
// register. With out_stall low the sustained rate is one pixel per cycle, set by the
// single read and single write port of each line store; a four-word queue decouples
// input from output, so the input stalls only once the output has been stalled long
// enough to fill it. Widths beyond MAX_WIDTH and sizes below 3 are saturated.
module lbp_3x3_operator #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [lbp_pkg::PIXEL_W-1:0]     gray_pixel,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic [lbp_pkg::PIXEL_W-1:0]     lbp_code,
  output logic                            last_code,
  output logic                            out_valid,
  input  logic                            out_stall
);

  logic [lbp_pkg::SIZE_W-1:0]        image_width, image_height;
  lbp_pkg::lbp_push_t                push;
  lbp_pkg::lbp_head_t                head;
  logic                              pop;
  logic [lbp_pkg::QUEUE_COUNT_W-1:0] queue_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lbp_pkg::IMAGE_WIDTH_RESET;
      image_height <= lbp_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (lbp_pkg::cfg_index_t'(cfg_index))
        lbp_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        lbp_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lbp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .gray_pixel   (gray_pixel),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .queue_count  (queue_count),
    .push         (push)
  );

  lbp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (queue_count)
  );

  lbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .lbp_code  (lbp_code),
    .last_code (last_code),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the 3x3 local binary pattern operator
`timescale 1ns / 100ps

module tb;

  localparam int LINE_DEPTH       = lbp_pkg::MAX_WIDTH_DEFAULT;
  localparam int DRAIN_CYCLES     = 12;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PIXELS    = 80;

  typedef struct packed {
    logic [lbp_pkg::PIXEL_W-1:0] code;
    logic                        last;
  } lbp_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  lbp_pkg::cfg_index_t          cfg_index = lbp_pkg::CFG_IMAGE_WIDTH;
  logic [lbp_pkg::SIZE_W-1:0]   cfg_data = '0;
  logic [lbp_pkg::PIXEL_W-1:0]  gray_pixel = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [lbp_pkg::PIXEL_W-1:0]  lbp_code;
  logic                         last_code;
  logic                         out_valid;
  logic                         out_stall = 1'b0;

  bit   [lbp_pkg::PIXEL_W-1:0]  upper_line [LINE_DEPTH];
  bit   [lbp_pkg::PIXEL_W-1:0]  middle_line [LINE_DEPTH];
  bit   [lbp_pkg::PIXEL_W-1:0]  win_cols [6];
  logic [lbp_pkg::ROW_W-1:0]    col_pos = '0;
  logic [lbp_pkg::ROW_W-1:0]    row_pos = '0;
  logic [lbp_pkg::SIZE_W-1:0]   width_reg = lbp_pkg::IMAGE_WIDTH_RESET;
  logic [lbp_pkg::SIZE_W-1:0]   height_reg = lbp_pkg::IMAGE_HEIGHT_RESET;
  lbp_result_t                  expected_codes [$];
  lbp_result_t                  code_want;

  int unsigned                  failures = 0;
  int unsigned                  pixel_count = 0;
  int unsigned                  stall_left = 0;
  bit                           no_idle = 1'b0;
  bit                           long_hold = 1'b0;
  bit                           narrow_pixels = 1'b0;
  logic [lbp_pkg::PIXEL_W-1:0]  pixel_base = '0;

  lbp_3x3_operator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .gray_pixel (gray_pixel),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .lbp_code   (lbp_code),
    .last_code  (last_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

  always #5 clk = ~clk;

  function automatic void predict_pixel(input logic [lbp_pkg::PIXEL_W-1:0] pixel);
    int unsigned eff_w;
    int unsigned eff_h;
    int unsigned idx;
    logic [lbp_pkg::PIXEL_W-1:0] above;
    logic [lbp_pkg::PIXEL_W-1:0] mid;
    logic [lbp_pkg::PIXEL_W-1:0] ctr;
    lbp_result_t res;
    eff_w = (width_reg < lbp_pkg::MIN_SIZE) ? lbp_pkg::MIN_SIZE :
            ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
    eff_h = (height_reg < lbp_pkg::MIN_SIZE) ? lbp_pkg::MIN_SIZE :
            ((height_reg > lbp_pkg::MAX_HEIGHT) ? lbp_pkg::MAX_HEIGHT : height_reg);
    idx = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
    above = upper_line[idx];
    mid = middle_line[idx];
    upper_line[idx] = mid;
    middle_line[idx] = pixel;
    if (row_pos >= 2 && col_pos >= 2) begin
      ctr = win_cols[4];
      res.code = '0;
      res.code[lbp_pkg::BIT_TOP_LEFT]     = (ctr >= win_cols[0]);
      res.code[lbp_pkg::BIT_TOP]          = (ctr >= win_cols[3]);
      res.code[lbp_pkg::BIT_TOP_RIGHT]    = (ctr >= above);
      res.code[lbp_pkg::BIT_RIGHT]        = (ctr >= mid);
      res.code[lbp_pkg::BIT_BOTTOM_RIGHT] = (ctr >= pixel);
      res.code[lbp_pkg::BIT_BOTTOM]       = (ctr >= win_cols[5]);
      res.code[lbp_pkg::BIT_BOTTOM_LEFT]  = (ctr >= win_cols[2]);
      res.code[lbp_pkg::BIT_LEFT]         = (ctr >= win_cols[1]);
      res.last = (row_pos + 1 >= eff_h) && (col_pos + 1 >= eff_w);
      expected_codes.push_back(res);
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = above;
    win_cols[4] = mid;
    win_cols[5] = pixel;
    if (col_pos + 1 >= eff_w) begin
      col_pos = '0;
      if (row_pos + 1 >= eff_h) begin
        row_pos = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [lbp_pkg::PIXEL_W-1:0] next_pixel();
    if (narrow_pixels) return pixel_base + lbp_pkg::PIXEL_W'($urandom_range(0, 2));
    return lbp_pkg::PIXEL_W'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [lbp_pkg::PIXEL_W-1:0] pixel);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    gray_pixel <= pixel;
    do @(posedge clk); while (in_stall);
    pixel_count++;
    predict_pixel(pixel);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lbp_pkg::cfg_index_t idx,
                           input logic [lbp_pkg::SIZE_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == lbp_pkg::CFG_IMAGE_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
  endtask

  // default size, then shrink width and height part way through the frame
  task automatic test_reset_sizes();
    repeat (lbp_pkg::IMAGE_WIDTH_RESET + 4) send_pixel(next_pixel());
    wait_idle();
    write_reg(lbp_pkg::CFG_IMAGE_WIDTH, 13'd6);
    repeat (3) send_pixel(next_pixel());
    wait_idle();
    write_reg(lbp_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    do send_pixel(next_pixel()); while (col_pos != 0 || row_pos != 0);
    wait_idle();
  endtask

  task automatic test_code_bits();
    int pos_of_bit [8] = '{0, 1, 2, 5, 8, 7, 6, 3};
    logic [lbp_pkg::PIXEL_W-1:0] centre [5] = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd255};
    logic [lbp_pkg::PIXEL_W-1:0] lo [5]     = '{8'd0, 8'd0, 8'd127, 8'd127, 8'd0};
    logic [lbp_pkg::PIXEL_W-1:0] hi [5]     = '{8'd255, 8'd255, 8'd129, 8'd129, 8'd255};
    logic [7:0]                  mask [5]   = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF};
    logic [lbp_pkg::PIXEL_W-1:0] patch [9];
    write_reg(lbp_pkg::CFG_IMAGE_WIDTH, 13'd3);
    write_reg(lbp_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    for (int p = 0; p < 5; p++) begin
      patch[4] = centre[p];
      for (int b = 0; b < 8; b++) patch[pos_of_bit[b]] = mask[p][b] ? hi[p] : lo[p];
      for (int k = 0; k < 9; k++) send_pixel(patch[k]);
    end
    wait_idle();
  endtask

  task automatic test_size_limits();
    no_idle = 1'b1;
    write_reg(lbp_pkg::CFG_IMAGE_WIDTH, 13'd0);
    write_reg(lbp_pkg::CFG_IMAGE_HEIGHT, 13'd0);
    do send_pixel(next_pixel()); while (col_pos != 0 || row_pos != 0);
    wait_idle();
    write_reg(lbp_pkg::CFG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(lbp_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    repeat (40) send_pixel(next_pixel());
    wait_idle();
    write_reg(lbp_pkg::CFG_IMAGE_WIDTH, 13'd8);
    repeat (25) send_pixel(next_pixel());
    wait_idle();
    write_reg(lbp_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    do send_pixel(next_pixel()); while (col_pos != 0 || row_pos != 0);
    wait_idle();
    no_idle = 1'b0;
  endtask

  // hold the output long enough that the input stalls
  task automatic test_backpressure();
    write_reg(lbp_pkg::CFG_IMAGE_WIDTH, 13'd8);
    write_reg(lbp_pkg::CFG_IMAGE_HEIGHT, 13'd6);
    no_idle = 1'b1;
    long_hold = 1'b1;
    do send_pixel(next_pixel()); while (col_pos != 0 || row_pos != 0);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned start_count;
    int unsigned r;
    start_count = pixel_count;
    while (pixel_count - start_count < RANDOM_PIXELS) begin
      r = $urandom_range(0, 99);
      write_reg(lbp_pkg::CFG_IMAGE_WIDTH,
                (r < 8) ? lbp_pkg::SIZE_W'($urandom_range(0, 2)) :
                (r < 20) ? lbp_pkg::SIZE_W'($urandom_range(13, 40)) :
                lbp_pkg::SIZE_W'($urandom_range(3, 12)));
      r = $urandom_range(0, 99);
      write_reg(lbp_pkg::CFG_IMAGE_HEIGHT,
                (r < 8) ? lbp_pkg::SIZE_W'($urandom_range(0, 2)) :
                lbp_pkg::SIZE_W'($urandom_range(3, 8)));
      no_idle = ($urandom_range(0, 3) == 0);
      narrow_pixels = ($urandom_range(0, 1) == 1);
      pixel_base = lbp_pkg::PIXEL_W'($urandom_range(0, 253));
      do send_pixel(next_pixel()); while (col_pos != 0 || row_pos != 0);
      wait_idle();
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:64]:  out_stall <= 1'b0;
          [65:94]: begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
          end
          default: begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(5, 25);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        $display("%0t unexpected word: lbp_code %02h last_code %0b",
                 $time, lbp_code, last_code);
        failures++;
      end else begin
        code_want = expected_codes.pop_front();
        if (lbp_code !== code_want.code) begin
          $display("%0t lbp_code expected %02h actual %02h",
                   $time, code_want.code, lbp_code);
          failures++;
        end
        if (last_code !== code_want.last) begin
          $display("%0t last_code expected %0b actual %0b",
                   $time, code_want.last, last_code);
          failures++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_sizes();
    test_code_bits();
    test_backpressure();
    test_size_limits();
    test_random_frames();
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lbp_pkg.sv
rtl/core/lbp_front.sv
rtl/core/lbp_queue.sv
rtl/core/lbp_back.sv
rtl/core/lbp_3x3_operator.sv
tb/tb.sv
